// ===== rtl/bsa_pkg.sv =====
package bsa_pkg;

   localparam int DIGIT_W = 4;
   localparam int WORD_W  = 64;

   localparam logic [DIGIT_W:0]   DIGIT_BASE = 5'd10;
   localparam logic [DIGIT_W:0]   DIGIT_MAX  = 5'd9;
   localparam logic [DIGIT_W-1:0] NINE       = 4'd9;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_SUB = 1'b1
   } opcode_type;

endpackage

// ===== rtl/bsa_dec_adder.sv =====
module bsa_dec_adder #(
   parameter int NUM_DIGITS = 16
) (
   input  logic [bsa_pkg::DIGIT_W*NUM_DIGITS-1:0] x,
   input  logic [bsa_pkg::DIGIT_W*NUM_DIGITS-1:0] y,
   input  logic                                   carry_in,
   output logic [bsa_pkg::DIGIT_W*NUM_DIGITS-1:0] sum,
   output logic                                   carry_out
);

   localparam int DW      = bsa_pkg::DIGIT_W;
   localparam int CHAIN_W = NUM_DIGITS + 1;

   logic [DW:0]            dsum [NUM_DIGITS];
   logic [NUM_DIGITS-1:0]  gen;
   logic [NUM_DIGITS-1:0]  prop_or_gen;
   logic [CHAIN_W-1:0]     chain;
   logic [NUM_DIGITS-1:0]  carry_into;

   // per-digit sums and decimal generate / propagate
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         dsum[i]        = {1'b0, x[DW*i +: DW]} + {1'b0, y[DW*i +: DW]};
         gen[i]         = dsum[i] >= bsa_pkg::DIGIT_BASE;
         prop_or_gen[i] = dsum[i] >= bsa_pkg::DIGIT_MAX;
      end
   end

   // resolve the digit carries with one binary add over the digit flags
   always_comb begin
      chain      = {1'b0, gen} + {1'b0, prop_or_gen} + CHAIN_W'(carry_in);
      carry_into = chain[NUM_DIGITS-1:0] ^ gen ^ prop_or_gen;
      carry_out  = chain[NUM_DIGITS];
   end

   always_comb begin
      logic [DW:0] corr;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         corr = dsum[i] + {{DW{1'b0}}, carry_into[i]};
         if (corr >= bsa_pkg::DIGIT_BASE) begin
            corr = corr - bsa_pkg::DIGIT_BASE;
         end
         sum[DW*i +: DW] = corr[DW-1:0];
      end
   end

endmodule

// ===== rtl/signed_bcd_add_subtract.sv =====
// Signed-magnitude BCD add / subtract.
// Each item passes the input register, then the result register, before rsp_valid.
// One item per cycle if rsp_stall is low; the decimal adder is one combinational pass.
// Reset: synchronous, active high; clears the stage valid bits only.
module signed_bcd_add_subtract #(
   parameter int NUM_DIGITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [63:0] req_a_digits,
   input  logic        req_a_negative,
   input  logic [63:0] req_b_digits,
   input  logic        req_b_negative,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_sum_digits,
   output logic        rsp_sum_negative,
   output logic        rsp_overflow,
   output logic        rsp_bad_digit
);

   localparam int DW    = bsa_pkg::DIGIT_W;
   localparam int MAG_W = DW * NUM_DIGITS;

   // input stage
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_op_ff;
   bsa_pkg::word_type      s1_a_ff, s1_b_ff;
   logic                   s1_a_neg_ff, s1_b_neg_ff;

   // result stage
   logic                   rsp_valid_ff, rsp_valid_in;
   bsa_pkg::word_type      sum_ff, sum_in;
   logic                   neg_ff, neg_in;
   logic                   ovf_ff, ovf_in;
   logic                   bad_ff, bad_in;

   logic                   req_accept;
   logic                   out_load;

   logic [MAG_W-1:0]       a_mag, b_mag;
   logic [MAG_W-1:0]       add_x, add_y, y_sel, add_sum;
   logic                   add_cin, add_cout;
   logic                   bad_nib;
   logic                   b_neg_eff, same_sign, a_ge_b, res_neg;

   always_comb begin
      out_load     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall    = s1_valid_ff && !out_load;
      req_accept   = req_valid && !req_stall;
      s1_valid_in  = req_accept || (s1_valid_ff && !out_load);
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= req_opcode;
         s1_a_ff     <= req_a_digits;
         s1_a_neg_ff <= req_a_negative;
         s1_b_ff     <= req_b_digits;
         s1_b_neg_ff <= req_b_negative;
      end
      if (out_load) begin
         sum_ff <= sum_in;
         neg_ff <= neg_in;
         ovf_ff <= ovf_in;
         bad_ff <= bad_in;
      end
   end

   always_comb begin
      a_mag   = s1_a_ff[MAG_W-1:0];
      b_mag   = s1_b_ff[MAG_W-1:0];
      bad_nib = 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bad_nib = bad_nib
                   || ({1'b0, a_mag[DW*i +: DW]} > bsa_pkg::DIGIT_MAX)
                   || ({1'b0, b_mag[DW*i +: DW]} > bsa_pkg::DIGIT_MAX);
      end
   end

   // subtract folds into add: flip the sign of b, then pick add or subtract of magnitudes
   always_comb begin
      b_neg_eff = (s1_op_ff == bsa_pkg::OP_ADD) ? s1_b_neg_ff : !s1_b_neg_ff;
      same_sign = s1_a_neg_ff == b_neg_eff;
      // packed BCD keeps decimal order, so a binary compare orders the magnitudes
      a_ge_b    = a_mag >= b_mag;

      if (same_sign || a_ge_b) begin
         add_x = a_mag;
         y_sel = b_mag;
      end else begin
         add_x = b_mag;
         y_sel = a_mag;
      end

      if (same_sign) begin
         add_y   = y_sel;
         add_cin = 1'b0;
         res_neg = s1_a_neg_ff;
      end else begin
         // ten's complement of the smaller magnitude
         for (int i = 0; i < NUM_DIGITS; i++) begin
            add_y[DW*i +: DW] = bsa_pkg::NINE - y_sel[DW*i +: DW];
         end
         add_cin = 1'b1;
         res_neg = a_ge_b ? s1_a_neg_ff : b_neg_eff;
      end
   end

   bsa_dec_adder #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_adder (
      .x         (add_x),
      .y         (add_y),
      .carry_in  (add_cin),
      .sum       (add_sum),
      .carry_out (add_cout)
   );

   always_comb begin
      if (bad_nib) begin
         sum_in = '0;
         neg_in = 1'b0;
         ovf_in = 1'b0;
         bad_in = 1'b1;
      end else begin
         sum_in = bsa_pkg::word_type'(add_sum);
         // never report negative zero
         neg_in = res_neg && (add_sum != '0);
         ovf_in = same_sign && add_cout;
         bad_in = 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sum_digits   = sum_ff;
   assign rsp_sum_negative = neg_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_bad_digit    = bad_ff;

`ifndef NO_ASSERTIONS
   a_no_neg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sum_digits == '0) |-> !rsp_sum_negative)
      else $error("negative zero on result");

   a_bad_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_digit |-> (rsp_sum_digits == '0) && !rsp_overflow
                                     && !rsp_sum_negative)
      else $error("bad digit result not cleared");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid && rsp_stall |=> s1_valid_ff && $stable(s1_a_ff)
                                               && $stable(s1_b_ff))
      else $error("input stage lost item under stall");

   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sum_digits >> MAG_W) == '0)
      else $error("unused result digits not zero");
`endif

endmodule
